// ===== hdl/wto_pkg.sv =====
// ----------------------------------------------------------------------------
// wto_pkg: shared types and constants of the wavetable oscillator
// Widths, configuration register indexes, queue item and state encodings.
// ----------------------------------------------------------------------------
package wto_pkg;

    localparam int TABLE_DEPTH     = 256;
    localparam int PHASE_FRAC_BITS = 16;
    localparam int PHASE_W         = 24;
    localparam int ADDR_W          = PHASE_W - PHASE_FRAC_BITS;
    localparam int SIZE_W          = ADDR_W + 1;
    localparam int VALUE_W         = 16;
    localparam int GAIN_W          = 16;
    localparam int BIAS_W          = 16;
    localparam int DIV_W           = 16;
    localparam int OUT_W           = 33;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // datapath widths
    localparam int PROD_W    = VALUE_W + PHASE_FRAC_BITS + 2;
    localparam int INTERP_W  = VALUE_W + PHASE_FRAC_BITS + 2;
    localparam int NUM_W     = INTERP_W + GAIN_W + 1;
    localparam int DIVD_W    = 36;
    localparam int DIV_STEPS = 4;
    localparam int DIV_CYCLES = DIVD_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_CYCLES + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE        = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_BIAS    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_DIVISOR = CFG_IDX_W'(3);

    // reset values
    localparam logic [PHASE_W-1:0] PHASE_STEP_RST = PHASE_W'(1) << PHASE_FRAC_BITS;
    localparam logic [SIZE_W-1:0]  TABLE_SIZE_RST = SIZE_W'(TABLE_DEPTH);
    localparam logic [DIV_W-1:0]   DIVISOR_RST    = DIV_W'(256);

    typedef enum logic [0:0] {
        FUNC_WRITE  = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

    typedef struct packed {
        logic [PHASE_W-1:0]       phase_step;
        logic [SIZE_W-1:0]        table_size;
        logic signed [BIAS_W-1:0] amplitude_bias;
        logic [DIV_W-1:0]         amplitude_divisor;
    } cfg_t;

    // one classified item between front and back
    typedef struct packed {
        logic                       func;
        logic [ADDR_W-1:0]          addr;      // write address or back entry
        logic [ADDR_W-1:0]          fwd_addr;  // forward entry
        logic [VALUE_W-1:0]         value;
        logic [PHASE_FRAC_BITS-1:0] frac;
        logic [GAIN_W-1:0]          gain;
    } qitem_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QPTR_W:0]   count;
    } queue_stat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL1,
        BK_ADD,
        BK_MUL2,
        BK_LOAD,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

// ===== hdl/wavetable_oscillator_interp_unit.sv =====
// ----------------------------------------------------------------------------
// wavetable_oscillator_interp_unit: wavetable oscillator, linear interpolation
// A write beat (func 0) stores one 16-bit table entry; a sample beat (func 1)
// returns one signed Q16.16 sample: the two table entries around the Q8.16
// phase are blended by the phase fraction, the bias is added, the sum is
// scaled by the envelope gain and divided by the divisor (truncated toward
// zero), and the phase then advances by the step, snapping to 0 at the table
// size. The front accepts a beat and resolves the phase and the neighbor
// addresses; a two-beat queue feeds the back. A write beat is handled in
// the back's idle state. A sample beat passes through table read, three
// arithmetic stages, divider load, the divider cycles (all but the last
// retire 4 quotient bits each over a 36-bit dividend, the last sees the
// divider finish) and the handoff to the result register. The divider
// sets the sustained sample rate. The result register lets the back start
// on the next beat while a finished sample waits to be popped. The user must
// write configuration only while the block is idle; the block does not
// enforce it. cfg_ready is always high; unknown register indexes are dropped.
// ----------------------------------------------------------------------------
module wavetable_oscillator_interp_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input beats
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 func,
    input  logic [7:0]                           entry_index,
    input  logic [wto_pkg::VALUE_W-1:0]          entry_value,
    input  logic [wto_pkg::GAIN_W-1:0]           env_gain,
    // result beats
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [wto_pkg::OUT_W-1:0]     sample_value,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wto_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wto_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import wto_pkg::*;

    cfg_t        cfg_reg;
    qitem_t      front_item, head_item;
    queue_stat_t q_stat;
    back_state_t back_state;
    logic        enq, deq;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step        <= PHASE_STEP_RST;
            cfg_reg.table_size        <= TABLE_SIZE_RST;
            cfg_reg.amplitude_bias    <= '0;
            cfg_reg.amplitude_divisor <= DIVISOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PHASE_STEP:
                    cfg_reg.phase_step <= cfg_data[PHASE_W-1:0];
                CFG_TABLE_SIZE:
                    cfg_reg.table_size <= cfg_data[SIZE_W-1:0];
                CFG_AMPLITUDE_BIAS:
                    cfg_reg.amplitude_bias <= $signed(cfg_data[BIAS_W-1:0]);
                CFG_AMPLITUDE_DIVISOR:
                    cfg_reg.amplitude_divisor <= cfg_data[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    // front: accept, phase, neighbor addresses
    wto_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .func        (func),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .env_gain    (env_gain),
        .cfg         (cfg_reg),
        .q_full      (q_stat.full),
        .full        (full),
        .enq         (enq),
        .item        (front_item)
    );

    wto_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .enq   (enq),
        .din   (front_item),
        .deq   (deq),
        .dout  (head_item),
        .stat  (q_stat)
    );

    // back: table, arithmetic, result register
    wto_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (head_item),
        .q_empty      (q_stat.empty),
        .deq          (deq),
        .cfg          (cfg_reg),
        .pop          (pop),
        .empty        (empty),
        .sample_value (sample_value),
        .state        (back_state)
    );

    // front never pushes into a full queue
    a_no_enq_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        enq |-> !q_stat.full)
        else $error("item queued while queue full");

    // back only takes items that are there
    a_no_deq_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        deq |-> !q_stat.empty)
        else $error("item taken from empty queue");

    // a result appears only as a sample finishes its handoff
    a_result_from_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && $past(empty)) |-> $past(back_state == BK_OUT))
        else $error("result appeared outside handoff");

endmodule

// ===== hdl/wto_front.sv =====
// ----------------------------------------------------------------------------
// wto_front: input side of the oscillator
// Accepts items, owns the phase accumulator and resolves table neighbors.
// ----------------------------------------------------------------------------
module wto_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              func,
    input  logic [7:0]                        entry_index,
    input  logic [wto_pkg::VALUE_W-1:0]       entry_value,
    input  logic [wto_pkg::GAIN_W-1:0]        env_gain,
    input  wto_pkg::cfg_t                     cfg,
    input  logic                              q_full,
    output logic                              full,
    output logic                              enq,
    output wto_pkg::qitem_t                   item
);
    import wto_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [SIZE_W-1:0]  size_eff;
    logic [PHASE_W:0]   limit;
    logic [PHASE_W:0]   sum;
    logic [PHASE_W-1:0] ph;
    logic [SIZE_W-1:0]  fwd_wide;

    always_comb
    begin
        size_eff = cfg.table_size;
        if (cfg.table_size > SIZE_W'(TABLE_DEPTH))
        begin
            size_eff = SIZE_W'(TABLE_DEPTH);
        end
        if (cfg.table_size == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        limit = {size_eff, {PHASE_FRAC_BITS{1'b0}}};

        // stale phase after the size shrank reads as zero
        ph = ({1'b0, phase_reg} < limit) ? phase_reg : '0;

        fwd_wide = {1'b0, ph[PHASE_W-1:PHASE_FRAC_BITS]} + SIZE_W'(1);
        sum      = {1'b0, ph} + {1'b0, cfg.phase_step};

        item.func     = func;
        item.addr     = (func == FUNC_SAMPLE) ? ph[PHASE_W-1:PHASE_FRAC_BITS]
                                              : entry_index;
        item.fwd_addr = (fwd_wide >= size_eff) ? '0 : fwd_wide[ADDR_W-1:0];
        item.value    = entry_value;
        item.frac     = ph[PHASE_FRAC_BITS-1:0];
        item.gain     = env_gain;

        full = q_full;
        enq  = push && !q_full;

        phase_next = phase_reg;
        if (enq && (func == FUNC_SAMPLE))
        begin
            phase_next = (sum >= limit) ? '0 : sum[PHASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== hdl/wto_queue.sv =====
// ----------------------------------------------------------------------------
// wto_queue: short item queue between front and back
// Two-entry FIFO of classified items.
// ----------------------------------------------------------------------------
module wto_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 enq,
    input  wto_pkg::qitem_t      din,
    input  logic                 deq,
    output wto_pkg::qitem_t      dout,
    output wto_pkg::queue_stat_t stat
);
    import wto_pkg::*;

    qitem_t            entry_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        case ({enq, deq})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
        stat.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
        stat.empty = (count_reg == '0);
        stat.count = count_reg;
        dout       = entry_q[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (enq)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entry_q[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== hdl/wto_div.sv =====
// ----------------------------------------------------------------------------
// wto_div: unsigned restoring divider
// Produces DIV_STEPS quotient bits per cycle while busy.
// ----------------------------------------------------------------------------
module wto_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wto_pkg::DIVD_W-1:0]  dividend,
    input  logic [wto_pkg::DIV_W-1:0]   divisor,
    output logic                        busy,
    output logic [wto_pkg::DIVD_W-1:0]  quotient
);
    import wto_pkg::*;

    logic [DIVD_W-1:0]    quot_reg, quot_next;
    logic [DIV_W:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]     dvsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            rem_next  = {rem_next[DIV_W-1:0], quot_next[DIVD_W-1]};
            quot_next = {quot_next[DIVD_W-2:0], 1'b0};
            if (rem_next >= {1'b0, dvsr_reg})
            begin
                rem_next     = rem_next - {1'b0, dvsr_reg};
                quot_next[0] = 1'b1;
            end
        end
        busy     = busy_reg;
        quotient = quot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_CYCLES);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

// ===== hdl/wto_back.sv =====
// ----------------------------------------------------------------------------
// wto_back: execution side of the oscillator
// Holds the wave table, interpolates, scales and divides, keeps the result.
// ----------------------------------------------------------------------------
module wto_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  wto_pkg::qitem_t                    item,
    input  logic                               q_empty,
    output logic                               deq,
    input  wto_pkg::cfg_t                      cfg,
    input  logic                               pop,
    output logic                               empty,
    output logic signed [wto_pkg::OUT_W-1:0]   sample_value,
    output wto_pkg::back_state_t               state
);
    import wto_pkg::*;

    back_state_t state_reg, state_next;

    logic [VALUE_W-1:0]         wave_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0]         rd_b_reg, rd_f_reg;
    logic [PHASE_FRAC_BITS-1:0] frac_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [INTERP_W-1:0] base_reg, interp_reg;
    logic signed [NUM_W-1:0]    num_reg;
    logic                       neg_reg;
    logic                       out_valid_reg;
    logic [OUT_W-1:0]           out_data_reg;

    logic                       mem_we, mem_re;
    logic                       div_start, div_busy, out_load;
    logic signed [VALUE_W:0]    diff;
    logic signed [VALUE_W+1:0]  bsum;
    logic signed [PROD_W-1:0]   prod;
    logic signed [NUM_W-1:0]    mag;
    logic [DIVD_W-1:0]          dividend;
    logic [DIV_W-1:0]           div_eff;
    logic [DIVD_W-1:0]          quotient;
    logic [DIVD_W-1:0]          signed_q;

    always_comb
    begin
        diff = $signed({1'b0, rd_f_reg}) - $signed({1'b0, rd_b_reg});
        prod = diff * $signed({1'b0, frac_reg});
        bsum = $signed({2'b00, rd_b_reg})
             + $signed({{2{cfg.amplitude_bias[BIAS_W-1]}}, cfg.amplitude_bias});
        mag      = num_reg[NUM_W-1] ? -num_reg : num_reg;
        dividend = DIVD_W'(mag[NUM_W-1:PHASE_FRAC_BITS]);
        div_eff  = (cfg.amplitude_divisor == '0) ? DIV_W'(1) : cfg.amplitude_divisor;
        signed_q = neg_reg ? -quotient : quotient;
    end

    always_comb
    begin
        state_next = state_reg;
        deq        = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    deq = 1'b1;
                    if (item.func == FUNC_SAMPLE)
                    begin
                        mem_re     = 1'b1;
                        state_next = BK_MUL1;
                    end
                    else
                    begin
                        mem_we = ({1'b0, item.addr} < SIZE_W'(TABLE_DEPTH));
                    end
                end
            end
            BK_MUL1: state_next = BK_ADD;
            BK_ADD:  state_next = BK_MUL2;
            BK_MUL2: state_next = BK_LOAD;
            BK_LOAD:
            begin
                div_start  = 1'b1;
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // table: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wave_mem[item.addr] <= item.value;
        end
        if (mem_re)
        begin
            rd_b_reg <= wave_mem[item.addr];
            rd_f_reg <= wave_mem[item.fwd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            frac_reg <= item.frac;
            gain_reg <= item.gain;
        end
        if (state_reg == BK_MUL1)
        begin
            prod_reg <= prod;
            base_reg <= $signed({bsum, {PHASE_FRAC_BITS{1'b0}}});
        end
        if (state_reg == BK_ADD)
        begin
            interp_reg <= base_reg + prod_reg;
        end
        if (state_reg == BK_MUL2)
        begin
            num_reg <= interp_reg * $signed({1'b0, gain_reg});
        end
        if (state_reg == BK_LOAD)
        begin
            neg_reg <= num_reg[NUM_W-1];
        end
        if (out_load)
        begin
            out_data_reg <= signed_q[OUT_W-1:0];
        end
    end

    wto_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (div_eff),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign empty        = !out_valid_reg;
    assign sample_value = $signed(out_data_reg);
    assign state        = state_reg;

endmodule
